// ----- design/i2c_seq_pkg.sv -----
// types and constants shared by the i2c byte sequencer modules
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package i2c_seq_pkg;

    localparam int BITS_PER_BYTE = 8;
    localparam int PHASE_W       = 5;
    localparam int TICK_W        = 16;

    localparam logic [PHASE_W-1:0] LAST_BIT_PHASE = PHASE_W'(2 * BITS_PER_BYTE);
    localparam logic [PHASE_W-1:0] SHORT_PHASES   = PHASE_W'(3);
    localparam logic [PHASE_W-1:0] BYTE_PHASES    = PHASE_W'(2 * BITS_PER_BYTE + 4);
    localparam logic [TICK_W-1:0]  PHASE_TICKS_RST = TICK_W'(100);

    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_START = 3'd1,
        OP_STOP  = 3'd2,
        OP_WRITE = 3'd3,
        OP_READ  = 3'd4
    } t_op;

    typedef struct packed {
        logic                     scl_level;
        logic                     sda_level;
        logic                     sda_released;
        logic                     busy_res;
        logic                     done_res;
        logic [BITS_PER_BYTE-1:0] rx_byte;
    } t_result;

endpackage

`default_nettype wire

// ----- design/i2c_seq_core.sv -----
// phase sequencer: command, phase and tick state plus bus drive registers
// depends on i2c_seq_pkg
`timescale 1ns / 1ps
`default_nettype none

module i2c_seq_core
    import i2c_seq_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_wr_en,
    input  wire logic [TICK_W-1:0]        i_cfg_wr_data,
    input  wire logic                     i_accept,
    input  wire logic [2:0]               i_operation,
    input  wire logic [BITS_PER_BYTE-1:0] i_tx_byte,
    input  wire logic                     i_send_ack,
    input  wire logic                     i_sda_in,
    output t_result                       o_result
);

    typedef struct packed {
        logic                     scl;
        logic                     sda;
        logic                     off;
        logic [BITS_PER_BYTE-1:0] shift;
    } t_drive;

    function automatic t_drive enter_phase(t_drive d, t_op cmd, logic [PHASE_W-1:0] p,
                                           logic ack);
        t_drive r;
        r = d;
        case (cmd)
            OP_START: begin
                if (p == PHASE_W'(1)) begin
                    r.sda = 1'b1;
                    r.scl = 1'b1;
                end else if (p == PHASE_W'(2)) begin
                    r.sda = 1'b0;
                end
            end
            OP_STOP: begin
                if (p == PHASE_W'(1)) begin
                    r.sda = 1'b0;
                    r.scl = 1'b1;
                end else if (p == PHASE_W'(2)) begin
                    r.sda = 1'b1;
                end
            end
            OP_WRITE: begin
                if (p == '0) begin
                    r.scl = 1'b0;
                end else if (p <= LAST_BIT_PHASE) begin
                    if (p[0]) begin
                        r.sda   = d.shift[BITS_PER_BYTE-1];
                        r.shift = {d.shift[BITS_PER_BYTE-2:0], 1'b0};
                        r.scl   = 1'b1;
                    end else begin
                        r.scl = 1'b0;
                    end
                end else if (p == LAST_BIT_PHASE + PHASE_W'(1)) begin
                    r.off = 1'b1;
                end else if (p == LAST_BIT_PHASE + PHASE_W'(2)) begin
                    r.scl = 1'b1;
                end else begin
                    r.scl = 1'b0;
                    r.off = 1'b0;
                    r.sda = 1'b1;
                end
            end
            OP_READ: begin
                if (p == '0) begin
                    r.scl = 1'b0;
                end else if (p <= LAST_BIT_PHASE) begin
                    if (p == PHASE_W'(1)) begin
                        r.off = 1'b1;
                        r.sda = 1'b1;
                    end
                    r.scl = p[0];
                end else if (p == LAST_BIT_PHASE + PHASE_W'(1)) begin
                    r.off = 1'b0;
                    r.sda = ~ack;
                end else if (p == LAST_BIT_PHASE + PHASE_W'(2)) begin
                    r.scl = 1'b1;
                end else begin
                    r.scl = 1'b0;
                end
            end
            default: begin
                r = d;
            end
        endcase
        return r;
    endfunction

    logic [TICK_W-1:0]        r_phase_ticks;
    t_op                      r_cmd,   n_cmd;
    logic [PHASE_W-1:0]       r_phase, n_phase;
    logic [TICK_W-1:0]        r_tick,  n_tick;
    logic                     r_ack,   n_ack;
    t_drive                   r_drv,   n_drv;

    logic                     start_cmd;
    logic [TICK_W-1:0]        tick_inc;
    logic [PHASE_W-1:0]       phase_inc;
    logic [PHASE_W-1:0]       phase_total;
    logic                     done;
    logic [BITS_PER_BYTE-1:0] rx;

    assign start_cmd = (r_cmd == OP_NONE) &&
                       ((i_operation == OP_START) || (i_operation == OP_STOP) ||
                        (i_operation == OP_WRITE) || (i_operation == OP_READ));

    always_comb begin
        n_cmd       = r_cmd;
        n_phase     = r_phase;
        n_tick      = r_tick;
        n_ack       = r_ack;
        n_drv       = r_drv;
        done        = 1'b0;
        rx          = '0;
        tick_inc    = '0;
        phase_inc   = '0;
        phase_total = SHORT_PHASES;

        if (start_cmd) begin
            n_cmd       = t_op'(i_operation);
            n_phase     = '0;
            n_tick      = '0;
            n_ack       = i_send_ack;
            n_drv.shift = (i_operation == OP_WRITE) ? i_tx_byte : '0;
            n_drv       = enter_phase(n_drv, n_cmd, '0, n_ack);
        end

        if (n_cmd != OP_NONE) begin
            tick_inc = n_tick + TICK_W'(1);
            if (tick_inc >= r_phase_ticks) begin
                n_tick = '0;
                if ((n_cmd == OP_READ) && n_phase[0] && (n_phase <= LAST_BIT_PHASE)) begin
                    n_drv.shift = {n_drv.shift[BITS_PER_BYTE-2:0], i_sda_in};
                end
                phase_inc   = n_phase + PHASE_W'(1);
                phase_total = ((n_cmd == OP_WRITE) || (n_cmd == OP_READ)) ?
                              BYTE_PHASES : SHORT_PHASES;
                if (phase_inc >= phase_total) begin
                    if (n_cmd == OP_READ) begin
                        rx = n_drv.shift;
                    end
                    done    = 1'b1;
                    n_cmd   = OP_NONE;
                    n_phase = '0;
                end else begin
                    n_phase = phase_inc;
                    n_drv   = enter_phase(n_drv, n_cmd, n_phase, n_ack);
                end
            end else begin
                n_tick = tick_inc;
            end
        end

        o_result.scl_level    = n_drv.scl;
        o_result.sda_level    = n_drv.sda;
        o_result.sda_released = n_drv.off;
        o_result.busy_res     = (n_cmd != OP_NONE);
        o_result.done_res     = done;
        o_result.rx_byte      = rx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ticks <= PHASE_TICKS_RST;
            r_cmd         <= OP_NONE;
            r_phase       <= '0;
            r_tick        <= '0;
            r_ack         <= 1'b0;
            r_drv         <= '{scl: 1'b1, sda: 1'b1, off: 1'b0, shift: '0};
        end else begin
            if (i_cfg_wr_en) begin
                r_phase_ticks <= i_cfg_wr_data;
            end
            if (i_accept) begin
                r_cmd   <= n_cmd;
                r_phase <= n_phase;
                r_tick  <= n_tick;
                r_ack   <= n_ack;
                r_drv   <= n_drv;
            end
        end
    end

endmodule

`default_nettype wire

// ----- design/i2c_seq_outq.sv -----
// two-entry result buffer: output register plus skid register
// depends on i2c_seq_pkg
`timescale 1ns / 1ps
`default_nettype none

module i2c_seq_outq
    import i2c_seq_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_data,
    output logic         o_full,
    output logic         o_valid,
    input  wire logic    i_stall,
    output t_result      o_data
);

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    pop;

    assign pop     = r_out_valid && !i_stall;
    assign o_full  = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_out_valid) begin
                r_out_valid <= i_push;
            end else if (pop) begin
                if (r_skid_valid) begin
                    r_skid_valid <= i_push;
                end else begin
                    r_out_valid <= i_push;
                end
            end else if (i_push) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || (pop && !r_skid_valid)) begin
            r_out <= i_data;
        end else if (pop) begin
            r_out <= r_skid;
        end
        if (i_push && r_out_valid && (!pop || r_skid_valid)) begin
            r_skid <= i_data;
        end
    end

endmodule

`default_nettype wire

// ----- design/i2c_master_byte_sequencer.sv -----
// i2c master byte sequencer top level: tick sequencer and result buffer
// depends on i2c_seq_pkg, i2c_seq_core, i2c_seq_outq
//
// usage: each input item is one bus tick and may carry a command (start,
// stop, write byte, read byte) which is taken only while no command runs.
// every accepted item gives exactly one result item with the scl/sda drive
// levels, the sda release flag, busy, a one-tick done pulse and the byte
// read (nonzero only on the done tick of a read).
// throughput: one item per cycle while input stall is low; the tick counter
// advances by one per item and the phase counter by one when ticks reach
// phase_ticks, in a single registered pass.
// the result side has an output register and a skid register, so input
// stall rises only when both hold results the receiver has not taken;
// a stalled result holds its value.
// reset (synchronous, active low): no command, scl and sda driven high,
// phase_ticks 100, result buffer empty. the user writes phase_ticks through
// the config port only while no command runs; the block does not check it.
`timescale 1ns / 1ps
`default_nettype none

module i2c_master_byte_sequencer
    import i2c_seq_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_wr_en,
    input  wire logic [TICK_W-1:0]        i_cfg_wr_data,
    input  wire logic                     i_in_valid,
    output logic                          o_in_stall,
    input  wire logic [2:0]               i_operation,
    input  wire logic [BITS_PER_BYTE-1:0] i_tx_byte,
    input  wire logic                     i_send_ack,
    input  wire logic                     i_sda_in,
    output logic                          o_out_valid,
    input  wire logic                     i_out_stall,
    output logic                          o_scl_level,
    output logic                          o_sda_level,
    output logic                          o_sda_released,
    output logic                          o_busy_res,
    output logic                          o_done_res,
    output logic [BITS_PER_BYTE-1:0]      o_rx_byte
);

    logic    accept;
    logic    full;
    t_result core_res;
    t_result out_res;

    assign o_in_stall = full;
    assign accept     = i_in_valid && !full;

    i2c_seq_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_accept      (accept),
        .i_operation   (i_operation),
        .i_tx_byte     (i_tx_byte),
        .i_send_ack    (i_send_ack),
        .i_sda_in      (i_sda_in),
        .o_result      (core_res)
    );

    i2c_seq_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (core_res),
        .o_full  (full),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (out_res)
    );

    assign o_scl_level    = out_res.scl_level;
    assign o_sda_level    = out_res.sda_level;
    assign o_sda_released = out_res.sda_released;
    assign o_busy_res     = out_res.busy_res;
    assign o_done_res     = out_res.done_res;
    assign o_rx_byte      = out_res.rx_byte;

endmodule

`default_nettype wire

// ----- bench/i2c_master_byte_sequencer_tb.sv -----
// testbench for the i2c master byte sequencer: directed and random bus ticks,
// a tick-level predictor of the scl/sda drive and a result checker
// depends on i2c_seq_pkg and i2c_master_byte_sequencer
`timescale 1ns / 1ps

module i2c_master_byte_sequencer_tb;
    import i2c_seq_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_cfg_wr_en;
    logic [TICK_W-1:0]        i_cfg_wr_data;
    logic                     i_in_valid;
    logic                     o_in_stall;
    logic [2:0]               i_operation;
    logic [BITS_PER_BYTE-1:0] i_tx_byte;
    logic                     i_send_ack;
    logic                     i_sda_in;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic                     o_scl_level;
    logic                     o_sda_level;
    logic                     o_sda_released;
    logic                     o_busy_res;
    logic                     o_done_res;
    logic [BITS_PER_BYTE-1:0] o_rx_byte;

    // predicted bus state
    logic [TICK_W-1:0]        ticks_per_phase = PHASE_TICKS_RST;
    t_op                      cmd_now = OP_NONE;
    logic [PHASE_W-1:0]       phase_now = '0;
    logic [TICK_W-1:0]        tick_now = '0;
    logic [BITS_PER_BYTE-1:0] shift_now = '0;
    logic                     ack_now = 1'b0;
    logic                     bus_scl = 1'b1;
    logic                     bus_sda = 1'b1;
    logic                     sda_off = 1'b0;

    t_result pending_levels[$];
    t_result seen_levels;
    t_result want_levels;
    int      fail_count = 0;
    int      results_seen = 0;
    int      ticks_sent = 0;
    int      cycle_count = 0;
    int      calm_left = 0;
    int      stall_left = 0;
    int      free_left = 0;

    i2c_master_byte_sequencer dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_operation    (i_operation),
        .i_tx_byte      (i_tx_byte),
        .i_send_ack     (i_send_ack),
        .i_sda_in       (i_sda_in),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_scl_level    (o_scl_level),
        .o_sda_level    (o_sda_level),
        .o_sda_released (o_sda_released),
        .o_busy_res     (o_busy_res),
        .o_done_res     (o_done_res),
        .o_rx_byte      (o_rx_byte)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** i2c_master_byte_sequencer: FAILED **");
            $finish;
        end
    end

    // drive levels entered at the start of phase p
    task automatic start_phase(input logic [PHASE_W-1:0] p);
        case (cmd_now)
            OP_START: begin
                if (p == 1) begin
                    bus_sda = 1'b1;
                    bus_scl = 1'b1;
                end else if (p == 2) begin
                    bus_sda = 1'b0;
                end
            end
            OP_STOP: begin
                if (p == 1) begin
                    bus_sda = 1'b0;
                    bus_scl = 1'b1;
                end else if (p == 2) begin
                    bus_sda = 1'b1;
                end
            end
            OP_WRITE: begin
                if (p == 0) begin
                    bus_scl = 1'b0;
                end else if (p <= LAST_BIT_PHASE) begin
                    if (p[0]) begin
                        bus_sda   = shift_now[BITS_PER_BYTE-1];
                        shift_now = {shift_now[BITS_PER_BYTE-2:0], 1'b0};
                        bus_scl   = 1'b1;
                    end else begin
                        bus_scl = 1'b0;
                    end
                end else if (p == LAST_BIT_PHASE + 1) begin
                    sda_off = 1'b1;
                end else if (p == LAST_BIT_PHASE + 2) begin
                    bus_scl = 1'b1;
                end else begin
                    bus_scl = 1'b0;
                    sda_off = 1'b0;
                    bus_sda = 1'b1;
                end
            end
            OP_READ: begin
                if (p == 0) begin
                    bus_scl = 1'b0;
                end else if (p <= LAST_BIT_PHASE) begin
                    if (p == 1) begin
                        sda_off = 1'b1;
                        bus_sda = 1'b1;
                    end
                    bus_scl = p[0];
                end else if (p == LAST_BIT_PHASE + 1) begin
                    sda_off = 1'b0;
                    bus_sda = ~ack_now;
                end else if (p == LAST_BIT_PHASE + 2) begin
                    bus_scl = 1'b1;
                end else begin
                    bus_scl = 1'b0;
                end
            end
            default: ;
        endcase
    endtask

    task automatic advance_bus_tick(input logic [2:0] op, input logic [7:0] tx,
                                    input logic ack, input logic sda);
        t_result r = '0;
        if (cmd_now == OP_NONE && op >= OP_START && op <= OP_READ) begin
            cmd_now   = t_op'(op);
            phase_now = '0;
            tick_now  = '0;
            ack_now   = ack;
            shift_now = (op == OP_WRITE) ? tx : 8'h00;
            start_phase('0);
        end
        if (cmd_now != OP_NONE) begin
            tick_now = tick_now + 1'b1;
            if (tick_now >= ticks_per_phase) begin
                tick_now = '0;
                if (cmd_now == OP_READ && phase_now[0] && phase_now <= LAST_BIT_PHASE)
                    shift_now = {shift_now[BITS_PER_BYTE-2:0], sda};
                phase_now = phase_now + 1'b1;
                if (phase_now >= ((cmd_now == OP_WRITE || cmd_now == OP_READ) ?
                                  BYTE_PHASES : SHORT_PHASES)) begin
                    if (cmd_now == OP_READ)
                        r.rx_byte = shift_now;
                    r.done_res = 1'b1;
                    cmd_now    = OP_NONE;
                    phase_now  = '0;
                end else begin
                    start_phase(phase_now);
                end
            end
        end
        r.scl_level    = bus_scl;
        r.sda_level    = bus_sda;
        r.sda_released = sda_off;
        r.busy_res     = (cmd_now != OP_NONE);
        pending_levels.push_back(r);
    endtask

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4) begin
            calm_left = $urandom_range(30, 100);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_tick(input logic [2:0] op, input logic [7:0] tx,
                             input logic ack, input logic sda);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_tx_byte   <= tx;
        i_send_ack  <= ack;
        i_sda_in    <= sda;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        advance_bus_tick(op, tx, ack, sda);
        ticks_sent++;
    endtask

    // tick until the running command ends, feeding rx_pattern on the sampled phases
    task automatic finish_command(input logic [7:0] rx_pattern, input bit noisy);
        logic [2:0] fill_op;
        logic       bit_in;
        while (cmd_now != OP_NONE) begin
            fill_op = noisy ? 3'($urandom_range(0, 7)) : 3'(OP_NONE);
            if (cmd_now == OP_READ && phase_now[0] && phase_now <= LAST_BIT_PHASE)
                bit_in = rx_pattern[3'd7 - phase_now[3:1]];
            else
                bit_in = 1'($urandom_range(0, 1));
            send_tick(fill_op, 8'($urandom), 1'($urandom_range(0, 1)), bit_in);
        end
    endtask

    task automatic run_command(input t_op op, input logic [7:0] tx, input logic ack,
                               input logic [7:0] rx_pattern, input bit noisy);
        send_tick(op, tx, ack, 1'($urandom_range(0, 1)));
        finish_command(rx_pattern, noisy);
    endtask

    task automatic wait_bus_quiet();
        i_in_valid <= 1'b0;
        while (pending_levels.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_ticks_per_phase(input logic [TICK_W-1:0] value);
        wait_bus_quiet();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en     <= 1'b0;
        ticks_per_phase = value;
    endtask

    // start, a few writes, up to two reads (acked but for the last, whose ack is random), stop
    task automatic run_transfer();
        int  n_wr;
        int  n_rd;
        bit  noisy;
        noisy = ($urandom_range(0, 3) == 0);
        n_wr  = $urandom_range(1, 3);
        n_rd  = $urandom_range(0, 2);
        run_command(OP_START, 8'($urandom), 1'b0, 8'h00, noisy);
        for (int i = 0; i < n_wr; i++)
            run_command(OP_WRITE, 8'($urandom), 1'($urandom_range(0, 1)), 8'h00, noisy);
        for (int i = 0; i < n_rd; i++)
            run_command(OP_READ, 8'($urandom),
                        (i < n_rd - 1) ? 1'b1 : 1'($urandom_range(0, 1)),
                        8'($urandom), noisy);
        if ($urandom_range(0, 9) == 0)
            wait_bus_quiet();
        run_command(OP_STOP, 8'($urandom), 1'b0, 8'h00, noisy);
    endtask

    // start at the reset phase length across its first phase boundary, then speed up
    task automatic test_default_rate();
        repeat (3) send_tick(OP_NONE, 8'h00, 1'b0, 1'b1);
        send_tick(OP_START, 8'h00, 1'b0, 1'b1);
        repeat (104) send_tick(OP_NONE, 8'h00, 1'b0, 1'b1);
        set_ticks_per_phase(16'd1);
        finish_command(8'h00, 1'b0);
    endtask

    task automatic test_each_command();
        set_ticks_per_phase(16'd1);
        run_command(OP_START, 8'h00, 1'b0, 8'h00, 1'b0);
        run_command(OP_WRITE, 8'h80, 1'b0, 8'h00, 1'b0);
        run_command(OP_WRITE, 8'h01, 1'b1, 8'h00, 1'b0);
        run_command(OP_READ, 8'h5A, 1'b1, 8'h55, 1'b0);
        run_command(OP_READ, 8'hA5, 1'b0, 8'hAA, 1'b0);
        run_command(OP_STOP, 8'h00, 1'b0, 8'h00, 1'b0);
    endtask

    // unused operation codes and commands that arrive while one runs
    task automatic test_ignored_ops();
        send_tick(3'd5, 8'hFF, 1'b1, 1'b0);
        send_tick(3'd6, 8'h00, 1'b0, 1'b1);
        send_tick(3'd7, 8'hFF, 1'b1, 1'b1);
        send_tick(OP_WRITE, 8'hC3, 1'b0, 1'b0);
        send_tick(OP_READ, 8'h00, 1'b1, 1'b1);
        send_tick(OP_START, 8'hFF, 1'b0, 1'b0);
        send_tick(OP_STOP, 8'h00, 1'b1, 1'b1);
        finish_command(8'h00, 1'b1);
        run_command(OP_READ, 8'h00, 1'b1, 8'h96, 1'b1);
        run_command(OP_STOP, 8'h00, 1'b0, 8'h00, 1'b1);
    endtask

    task automatic test_zero_length();
        set_ticks_per_phase(16'd0);
        run_command(OP_START, 8'h00, 1'b0, 8'h00, 1'b0);
        run_command(OP_WRITE, 8'h69, 1'b0, 8'h00, 1'b0);
        wait_bus_quiet();
        run_command(OP_READ, 8'h00, 1'b0, 8'hE1, 1'b0);
        run_command(OP_STOP, 8'h00, 1'b0, 8'h00, 1'b0);
    endtask

    task automatic test_phase_lengths();
        int lens[2] = '{2, 3};
        foreach (lens[k]) begin
            set_ticks_per_phase(16'(lens[k]));
            run_command(OP_START, 8'h00, 1'b0, 8'h00, 1'b0);
            wait_bus_quiet();
            run_command(OP_READ, 8'h00, 1'($urandom_range(0, 1)), 8'($urandom), 1'b0);
            run_command(OP_STOP, 8'h00, 1'b0, 8'h00, 1'b0);
        end
    endtask

    task automatic test_random_traffic();
        int mark;
        int r;
        logic [2:0] op;
        for (int chunk = 0; chunk < 2; chunk++) begin
            case (chunk)
                0:       set_ticks_per_phase(16'd1);
                default: set_ticks_per_phase(16'($urandom_range(0, 1)));
            endcase
            mark = ticks_sent;
            while (ticks_sent - mark < 30) begin
                r = $urandom_range(0, 99);
                if (r < 75) begin
                    run_transfer();
                end else if (r < 90) begin
                    run_command(t_op'($urandom_range(1, 4)), 8'($urandom),
                                1'($urandom_range(0, 1)), 8'($urandom), 1'b1);
                end else begin
                    repeat ($urandom_range(1, 6)) begin
                        op = 3'($urandom_range(0, 3));
                        if (op != 0)
                            op = op + 3'd4;
                        send_tick(op, 8'($urandom), 1'($urandom_range(0, 1)),
                                  1'($urandom_range(0, 1)));
                    end
                end
            end
        end
    endtask

    // slowest phase setting: the command is left running at the end of the run
    task automatic test_longest_phase();
        set_ticks_per_phase(16'hFFFF);
        repeat (2) send_tick(OP_NONE, 8'($urandom), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)));
        send_tick(OP_START, 8'h00, 1'b0, 1'b1);
        repeat (30) send_tick(3'($urandom_range(0, 7)), 8'($urandom),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            seen_levels = {o_scl_level, o_sda_level, o_sda_released, o_busy_res,
                           o_done_res, o_rx_byte};
            if (pending_levels.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("result %0d arrived with none expected", results_seen);
            end else begin
                want_levels = pending_levels.pop_front();
                if (seen_levels.scl_level !== want_levels.scl_level ||
                    seen_levels.sda_level !== want_levels.sda_level ||
                    seen_levels.sda_released !== want_levels.sda_released ||
                    seen_levels.busy_res !== want_levels.busy_res ||
                    seen_levels.done_res !== want_levels.done_res ||
                    seen_levels.rx_byte !== want_levels.rx_byte) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display({"result %0d expected/actual: scl %b/%b sda %b/%b",
                                  " released %b/%b busy %b/%b done %b/%b rx %h/%h"},
                                 results_seen,
                                 want_levels.scl_level, seen_levels.scl_level,
                                 want_levels.sda_level, seen_levels.sda_level,
                                 want_levels.sda_released, seen_levels.sda_released,
                                 want_levels.busy_res, seen_levels.busy_res,
                                 want_levels.done_res, seen_levels.done_res,
                                 want_levels.rx_byte, seen_levels.rx_byte);
                end
            end
            results_seen++;
        end
        // receiver stalls: short bursts, occasional long ones, calm stretches
        if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left--;
        end else if (free_left > 0) begin
            i_out_stall <= 1'b0;
            free_left--;
        end else begin
            i_out_stall <= 1'b0;
            free_left  = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150)
                                                     : $urandom_range(0, 4);
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50)
                                                     : $urandom_range(1, 3);
        end
    end

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= '0;
        i_in_valid    <= 1'b0;
        i_operation   <= OP_NONE;
        i_tx_byte     <= '0;
        i_send_ack    <= 1'b0;
        i_sda_in      <= 1'b1;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_default_rate();
        test_each_command();
        test_ignored_ops();
        test_zero_length();
        test_phase_lengths();
        test_random_traffic();
        test_longest_phase();

        wait_bus_quiet();
        repeat (6) @(posedge i_clk);
        if (fail_count == 0 && pending_levels.size() == 0) begin
            $display("** i2c_master_byte_sequencer: PASSED **");
        end else begin
            $display("** i2c_master_byte_sequencer: FAILED **");
        end
        $finish;
    end

endmodule
